// ===== hw/rtl/hpg_pkg.sv =====
// Shared types and constants of the hypotrochoid point generator.
// Holds fixed widths, the 1/(2*pi) constant, the CORDIC arctangent table and register codes.
// No dependencies.
package hpg_pkg;

    // Field widths
    localparam int CFG_W     = 24;              // radii and center offsets
    localparam int COUNT_W   = 21;              // point count
    localparam int POS_W     = 27;              // output coordinates
    localparam int DIFF_W    = CFG_W + 1;       // R - r
    localparam int MAG_W     = CFG_W;           // |R - r| and |r|
    localparam int DEN_W     = MAG_W + COUNT_W; // |r| * N
    localparam int SCALE_W   = 7;               // bits added by the times-80 step
    localparam int FRAC_W    = 32;              // fraction bits out of the divider
    localparam int PH_W      = 32;              // phase in turns
    localparam int CD_W      = 34;              // CORDIC datapath width
    localparam int PROD_W    = DIFF_W + CD_W + 1;
    localparam int Q30_SHIFT = 30;
    localparam int ATAN_N    = 32;

    localparam int unsigned ANGLE_SCALE = 80;   // total sweep in radians

    // 2^64 / (2*pi), split into halves
    localparam logic [31:0] INV_HI = 32'h28BE60DB;
    localparam logic [31:0] INV_LO = 32'h9391054A;

    // CORDIC start vector, gain compensated, Q30
    localparam logic signed [CD_W-1:0] CORDIC_X0 = 34'sd652032874;

    // atan(2^-k) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_OUTER  = 3'd0,
        REG_INNER  = 3'd1,
        REG_PEN    = 3'd2,
        REG_CX     = 3'd3,
        REG_CY     = 3'd4,
        REG_COUNT  = 3'd5
    } cfg_reg_t;

endpackage

// ===== hw/rtl/hpg_phase.sv =====
// Angle to phase unit: two lanes of pipelined restoring division (one quotient bit
// per stage) followed by the fixed-point multiply by 1/(2*pi). Uses hpg_pkg.
module hpg_phase #(
    parameter int M_W = 51
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [M_W-1:0]              m1,
    input  logic [M_W-1:0]              m2,
    input  logic [hpg_pkg::DEN_W-1:0]   den1,
    input  logic [hpg_pkg::DEN_W-1:0]   den2,
    input  logic                        neg2,
    output logic                        out_valid,
    output logic [hpg_pkg::PH_W-1:0]    phase1,
    output logic [hpg_pkg::PH_W-1:0]    phase2
);
    import hpg_pkg::*;

    localparam int Q_W    = M_W + FRAC_W;
    localparam int QH_W   = M_W - 32;
    localparam int TAIL   = 4;
    localparam int VLD_N  = Q_W + TAIL;

    logic [M_W-1:0]   m_in   [2];
    logic [DEN_W-1:0] den_in [2];
    logic             neg_in [2];

    logic [DEN_W-1:0] rem_reg [2][Q_W];
    logic [Q_W-1:0]   acc_reg [2][Q_W];
    logic             vld_reg [VLD_N];

    logic [63:0] pll_reg [2];
    logic [31:0] phl_reg [2];
    logic [31:0] plh_reg [2];
    logic [63:0] pfh_reg [2];
    logic [31:0] pfl_reg [2];
    logic [63:0] s1_reg  [2];
    logic [63:0] s2_reg  [2];
    logic [63:0] w_reg   [2];
    logic [PH_W-1:0] phase_reg [2];

    assign m_in[0]   = m1;
    assign m_in[1]   = m2;
    assign den_in[0] = den1;
    assign den_in[1] = den2;
    assign neg_in[0] = 1'b0;
    assign neg_in[1] = neg2;

    // Valid chain through divider and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD_N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < VLD_N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        // Restoring division: M * 2^32 / D, one quotient bit per stage
        for (genvar k = 0; k < Q_W; k++)
        begin : g_div
            logic [DEN_W-1:0] rem_in;
            logic [Q_W-1:0]   acc_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign acc_in = {m_in[l], {FRAC_W{1'b0}}};
            end
            else
            begin : g_next
                assign rem_in = rem_reg[l][k-1];
                assign acc_in = acc_reg[l][k-1];
            end

            assign trial = {rem_in, acc_in[Q_W-1]};
            assign diff  = trial - {1'b0, den_in[l]};
            assign ge    = (trial >= {1'b0, den_in[l]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    acc_reg[l][k] <= {acc_in[Q_W-2:0], ge};
                end
            end
        end

        // Quotient split into integer and fraction words
        logic [M_W-1:0]  quo;
        logic [31:0]     q_lo;
        logic [QH_W-1:0] q_hi;
        logic [31:0]     frac;
        logic [63:0]     prod_ll;
        logic [63:0]     prod_hl;
        logic [63:0]     prod_lh;
        logic [63:0]     prod_fh;
        logic [63:0]     prod_fl;
        logic [63:0]     w_neg;

        assign quo  = acc_reg[l][Q_W-1][Q_W-1:FRAC_W];
        assign frac = acc_reg[l][Q_W-1][FRAC_W-1:0];
        assign q_lo = quo[31:0];
        assign q_hi = quo[M_W-1:32];

        assign prod_ll = 64'(q_lo) * 64'(INV_LO);
        assign prod_hl = 64'(q_hi) * 64'(INV_LO);
        assign prod_lh = 64'(q_lo) * 64'(INV_HI);
        assign prod_fh = 64'(frac) * 64'(INV_HI);
        assign prod_fl = 64'(frac) * 64'(INV_LO);
        assign w_neg   = 64'd0 - w_reg[l];

        // Partial products, then sums, then sign and phase
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pll_reg[l]   <= prod_ll;
                phl_reg[l]   <= prod_hl[31:0];
                plh_reg[l]   <= prod_lh[31:0];
                pfh_reg[l]   <= prod_fh;
                pfl_reg[l]   <= prod_fl[63:32];
                s1_reg[l]    <= pll_reg[l] + pfh_reg[l];
                s2_reg[l]    <= {phl_reg[l] + plh_reg[l], pfl_reg[l]};
                w_reg[l]     <= s1_reg[l] + s2_reg[l];
                phase_reg[l] <= neg_in[l] ? w_neg[63:32] : w_reg[l][63:32];
            end
        end
    end

    assign out_valid = vld_reg[VLD_N-1];
    assign phase1    = phase_reg[0];
    assign phase2    = phase_reg[1];

endmodule

// ===== hw/rtl/hpg_cordic.sv =====
// Two-lane pipelined rotation CORDIC: phase in turns to cos and sin in Q30.
// One micro-rotation per stage, quadrant fold in front. Uses hpg_pkg.
module hpg_cordic #(
    parameter int STAGES = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [hpg_pkg::PH_W-1:0]         phase1,
    input  logic [hpg_pkg::PH_W-1:0]         phase2,
    output logic                             out_valid,
    output logic signed [hpg_pkg::CD_W-1:0]  cos1,
    output logic signed [hpg_pkg::CD_W-1:0]  sin1,
    output logic signed [hpg_pkg::CD_W-1:0]  cos2,
    output logic signed [hpg_pkg::CD_W-1:0]  sin2
);
    import hpg_pkg::*;

    localparam int VLD_N = STAGES + 2;

    logic [PH_W-1:0]        ph_in [2];
    logic signed [CD_W-1:0] x_reg [2][STAGES+1];
    logic signed [CD_W-1:0] y_reg [2][STAGES+1];
    logic signed [CD_W-1:0] z_reg [2][STAGES+1];
    logic                   flip_reg [2][STAGES+1];
    logic signed [CD_W-1:0] c_reg [2];
    logic signed [CD_W-1:0] s_reg [2];
    logic                   vld_reg [VLD_N];

    assign ph_in[0] = phase1;
    assign ph_in[1] = phase2;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD_N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < VLD_N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        // Fold phases in [1/4, 3/4) turn by a half turn
        logic            flip;
        logic [PH_W-1:0] ph_fold;

        assign flip    = ph_in[l][PH_W-1] ^ ph_in[l][PH_W-2];
        assign ph_fold = ph_in[l] ^ {flip, {(PH_W-1){1'b0}}};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[l][0]    <= CORDIC_X0;
                y_reg[l][0]    <= '0;
                z_reg[l][0]    <= CD_W'(signed'(ph_fold));
                flip_reg[l][0] <= flip;
            end
        end

        // Micro-rotations
        for (genvar k = 0; k < STAGES; k++)
        begin : g_rot
            logic signed [CD_W-1:0] x_sh;
            logic signed [CD_W-1:0] y_sh;
            logic signed [CD_W-1:0] ang;

            assign x_sh = x_reg[l][k] >>> k;
            assign y_sh = y_reg[l][k] >>> k;
            assign ang  = signed'(CD_W'(ATAN_TURNS[k]));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_reg[l][k][CD_W-1])
                    begin
                        x_reg[l][k+1] <= x_reg[l][k] - y_sh;
                        y_reg[l][k+1] <= y_reg[l][k] + x_sh;
                        z_reg[l][k+1] <= z_reg[l][k] - ang;
                    end
                    else
                    begin
                        x_reg[l][k+1] <= x_reg[l][k] + y_sh;
                        y_reg[l][k+1] <= y_reg[l][k] - x_sh;
                        z_reg[l][k+1] <= z_reg[l][k] + ang;
                    end
                    flip_reg[l][k+1] <= flip_reg[l][k];
                end
            end
        end

        // Undo the fold
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[l] <= flip_reg[l][STAGES] ? -x_reg[l][STAGES] : x_reg[l][STAGES];
                s_reg[l] <= flip_reg[l][STAGES] ? -y_reg[l][STAGES] : y_reg[l][STAGES];
            end
        end
    end

    assign out_valid = vld_reg[VLD_N-1];
    assign cos1      = c_reg[0];
    assign sin1      = s_reg[0];
    assign cos2      = c_reg[1];
    assign sin2      = s_reg[1];

endmodule

// ===== hw/rtl/hypotrochoid_point_generator.sv =====
// Hypotrochoid point generator, top level.
// Instantiates hpg_phase and hpg_cordic; uses hpg_pkg.
//
// Usage:
//   Write the six configuration registers over the cfg channel (index 0..5:
//   outer radius, inner radius, pen radius, center x, center y, point count)
//   while no transaction is in flight. cfg_ready is always high; indexes past
//   the list are dropped. Reset loads the default curve and empties the pipe.
//   Each input transaction carries one point index and yields exactly one
//   output transaction with pos_x, pos_y and the invalid flag (set, with zero
//   coordinates, when the inner radius is zero).
//   Throughput: one point per clock while the pipe is not frozen. The path
//   runs through the bit-per-stage dividers of the two angles (INDEX_BITS + 63
//   stages each) and then the CORDIC stages.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipe freezes and loses nothing; the input stage still takes one more
//   transaction if it is empty.
module hypotrochoid_point_generator #(
    parameter int INDEX_BITS    = 20,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [hpg_pkg::CFG_W-1:0]         cfg_data,
    // input points
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [INDEX_BITS-1:0]             point_index,
    // output points
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hpg_pkg::POS_W-1:0]  pos_x,
    output logic signed [hpg_pkg::POS_W-1:0]  pos_y,
    output logic                              invalid
);
    import hpg_pkg::*;

    localparam int A_W = INDEX_BITS + SCALE_W;
    localparam int M_W = MAG_W + A_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (Q30_SHIFT - 1);

    // Configuration registers
    logic signed [CFG_W-1:0] outer_reg, inner_reg, pen_reg, cx_reg, cy_reg;
    logic [COUNT_W-1:0]      count_reg;

    // Values derived from configuration
    logic signed [DIFF_W-1:0] diff_reg;
    logic [MAG_W-1:0]         adiff_reg, ainner_reg;
    logic [COUNT_W-1:0]       neff_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic                     neg_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic                     inner_zero;

    // Front pipeline
    logic                  en, accept;
    logic                  v0_reg, v1_reg, v2_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [A_W-1:0]        a_reg;
    logic [M_W-1:0]        m1_reg, m2_reg;

    // Between units
    logic                    ph_valid;
    logic [PH_W-1:0]         phase1, phase2;
    logic                    cs_valid;
    logic signed [CD_W-1:0]  cos1, sin1, cos2, sin2;

    // Back end
    logic                     vf1_reg, vf2_reg, out_valid_reg;
    logic signed [PROD_W-1:0] dc1_reg, pc2_reg, ds1_reg, ps2_reg;
    logic signed [PROD_W-1:0] sx_reg, sy_reg;
    logic signed [PROD_W-1:0] px_full, py_full;
    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic                     invalid_reg;

    // Configuration write decode
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg <= 24'sd25600;
            inner_reg <= 24'sd512;
            pen_reg   <= 24'sd20480;
            cx_reg    <= '0;
            cy_reg    <= '0;
            count_reg <= 21'd20000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OUTER: outer_reg <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                REG_PEN:   pen_reg   <= cfg_data;
                REG_CX:    cx_reg    <= cfg_data;
                REG_CY:    cy_reg    <= cfg_data;
                REG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Derived constants, registered; den2_reg is built from the registered |r| and N
    assign diff_next  = DIFF_W'(outer_reg) - DIFF_W'(inner_reg);
    assign inner_zero = (inner_reg == '0);

    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        adiff_reg  <= diff_next[DIFF_W-1] ? MAG_W'(-diff_next) : MAG_W'(diff_next);
        ainner_reg <= inner_reg[CFG_W-1] ? MAG_W'(-DIFF_W'(inner_reg))
                                         : MAG_W'(inner_reg);
        neff_reg   <= (count_reg < COUNT_W'(2)) ? COUNT_W'(2) : count_reg;
        neg_reg    <= diff_next[DIFF_W-1] ^ inner_reg[CFG_W-1];
        den2_reg   <= DEN_W'(ainner_reg) * DEN_W'(neff_reg);
    end

    // Global advance; the input stage can also fill while stalled if empty
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en || !v0_reg;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v0_reg <= accept;
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
            end
            else if (accept)
            begin
                v0_reg <= 1'b1;
            end
        end
    end

    // Index capture, times 80, times |R - r|
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= point_index;
        end
        if (en)
        begin
            a_reg  <= A_W'(idx_reg) * A_W'(ANGLE_SCALE);
            m1_reg <= M_W'(a_reg);
            m2_reg <= M_W'(adiff_reg) * M_W'(a_reg);
        end
    end

    hpg_phase #(
        .M_W (M_W)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .m1        (m1_reg),
        .m2        (m2_reg),
        .den1      (DEN_W'(neff_reg)),
        .den2      (den2_reg),
        .neg2      (neg_reg),
        .out_valid (ph_valid),
        .phase1    (phase1),
        .phase2    (phase2)
    );

    hpg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ph_valid),
        .phase1    (phase1),
        .phase2    (phase2),
        .out_valid (cs_valid),
        .cos1      (cos1),
        .sin1      (sin1),
        .cos2      (cos2),
        .sin2      (sin2)
    );

    // Back-end valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf1_reg       <= 1'b0;
            vf2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vf1_reg       <= cs_valid;
            vf2_reg       <= vf1_reg;
            out_valid_reg <= vf2_reg;
        end
    end

    // Scale by radii, round, shift out of Q30 and offset
    assign px_full = (sx_reg >>> Q30_SHIFT) + PROD_W'(cx_reg);
    assign py_full = (sy_reg >>> Q30_SHIFT) + PROD_W'(cy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc1_reg     <= PROD_W'(diff_reg) * PROD_W'(cos1);
            pc2_reg     <= PROD_W'(pen_reg) * PROD_W'(cos2);
            ds1_reg     <= PROD_W'(diff_reg) * PROD_W'(sin1);
            ps2_reg     <= PROD_W'(pen_reg) * PROD_W'(sin2);
            sx_reg      <= dc1_reg + pc2_reg + ROUND_HALF;
            sy_reg      <= ds1_reg - ps2_reg + ROUND_HALF;
            pos_x_reg   <= inner_zero ? '0 : px_full[POS_W-1:0];
            pos_y_reg   <= inner_zero ? '0 : py_full[POS_W-1:0];
            invalid_reg <= inner_zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign invalid   = invalid_reg;

endmodule
